FILE: hdl/bpa_pkg.sv
// Shared constants, types and helper functions of the bitmap page allocator.
package bpa_pkg;

	localparam int NUM_PAGES = 1024;
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int HINT_W    = $clog2(NUM_PAGES + 1);
	localparam int IDX_W     = 10;
	localparam int CNT_W     = 11;
	localparam int OP_W      = 2;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	typedef logic [WORD_BITS-1:0] map_word_t;
	typedef logic [WORD_AW-1:0]   word_t;
	typedef logic [HINT_W-1:0]    hint_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [OP_W-1:0]      op_t;

	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FREE  = 2'd1;
	localparam op_t OP_QUERY = 2'd2;

	localparam word_t LAST_WORD = word_t'(MAP_WORDS - 1);
	localparam int    LAST_REM  = NUM_PAGES - WORD_BITS * (MAP_WORDS - 1);
	// Bits of the last map word that lie beyond the page range count as used.
	localparam map_word_t LAST_PAD = (LAST_REM >= WORD_BITS) ? map_word_t'(0) :
		~((map_word_t'(1) << LAST_REM) - map_word_t'(1));

	function automatic map_word_t pad_mask(input word_t w);
		return (w == LAST_WORD) ? LAST_PAD : map_word_t'(0);
	endfunction

	// Returns {found, position} of the lowest zero bit of a map word.
	function automatic logic [BIT_W:0] find_zero(input map_word_t w);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = {1'b1, BIT_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/bitmap_page_allocator.sv
// Free and query read the map word, update or check it, then finish and load the output; a
// failed allocate (map full) skips the read-modify-write and goes straight to the finishing
// state; a successful allocate sets the bit and searches onward for the next lowest free page.
// One item at a time: a new input beat is taken only while the sequencer is idle.
// Reset (arst_n low, asynchronous) marks every page free, clears the used count and the
// free-page hint, and drops both valid signals; the map needs no clearing pass.
module bitmap_page_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// Bits from low up: page_index[9:0], zero fill [15:10].
	input  logic [bpa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// Bits from low up: opcode[1:0].
	input  logic [bpa_pkg::OP_W-1:0]       s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// Bits from low up: success[0], result_page[10:1], page_free[11],
	// used_count[22:12], zero fill [23].
	output logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import bpa_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RMW  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	// The used map: one bit per page, 64 pages to a word. A word that has never
	// been written reads as all free through its valid flag.
	map_word_t map_mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] map_vld_q;
	map_word_t rd_data_s1;
	logic      rd_vld_s1;

	logic [1:0] state_q;
	op_t        op_q;
	idx_t       idx_q;      // page addressed by the item (the hint page for allocate)
	word_t      word_q;     // map word held in the read register
	hint_t      hint_q;     // lowest free page, NUM_PAGES when the map is full
	cnt_t       count_q;

	// Result of the item in work.
	logic       res_ok_q;
	idx_t       res_page_q;
	logic       res_free_q;

	// Output register.
	logic       m_valid_q;
	logic       m_ok_q;
	idx_t       m_page_q;
	logic       m_free_q;
	cnt_t       m_count_q;

	logic           in_beat;
	map_word_t      rd_word;
	map_word_t      bit_mask;
	map_word_t      alloc_word;
	map_word_t      srch_word;
	logic [BIT_W:0] zero_hit;
	logic           page_used;
	logic           idx_in_range;
	word_t          scan_next;
	word_t          rd_addr;
	logic           wr_en;
	map_word_t      wr_data;
	hint_t          found_hint;
	logic           out_free;

	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;

	// Read-modify-write datapath on the word that was read in the previous cycle.
	assign rd_word      = rd_vld_s1 ? rd_data_s1 : map_word_t'(0);
	assign bit_mask     = map_word_t'(1) << idx_q[BIT_W-1:0];
	assign page_used    = rd_word[idx_q[BIT_W-1:0]];
	assign alloc_word   = rd_word | bit_mask;
	assign idx_in_range = hint_t'(idx_q) < hint_t'(NUM_PAGES);
	assign scan_next    = word_q + word_t'(1);

	// Pages below the hint are all used, so after the allocated bit is set the
	// lowest zero of the word is the next free page.
	assign srch_word  = ((state_q == ST_RMW) ? alloc_word : rd_word) | pad_mask(word_q);
	assign zero_hit   = find_zero(srch_word);
	assign found_hint = hint_t'({word_q, zero_hit[BIT_W-1:0]});

	assign wr_en = (state_q == ST_RMW) &&
		((op_q == OP_ALLOC) || ((op_q == OP_FREE) && idx_in_range && page_used));
	assign wr_data = (op_q == OP_ALLOC) ? alloc_word : (rd_word & ~bit_mask);

	// While idle the read fetches the word of the next item; during a search
	// it fetches the word after the current one.
	always_comb begin
		if (state_q == ST_IDLE) begin
			if (s_axis_tuser == OP_ALLOC) begin
				rd_addr = hint_q[BIT_W +: WORD_AW];
			end else begin
				rd_addr = s_axis_tdata[BIT_W +: WORD_AW];
			end
		end else begin
			rd_addr = scan_next;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[word_q] <= wr_data;
		end
		rd_data_s1 <= map_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				map_vld_q[word_q] <= 1'b1;
			end
			rd_vld_s1 <= map_vld_q[rd_addr];
		end
	end

	// Control sequencer, hint and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hint_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						if ((s_axis_tuser == OP_ALLOC) && (hint_q == hint_t'(NUM_PAGES))) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RMW;
						end
					end
				end
				ST_RMW: begin
					case (op_q)
						OP_ALLOC: begin
							count_q <= count_q + cnt_t'(1);
							if (zero_hit[BIT_W]) begin
								hint_q  <= found_hint;
								state_q <= ST_DONE;
							end else if (word_q == LAST_WORD) begin
								hint_q  <= hint_t'(NUM_PAGES);
								state_q <= ST_DONE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						OP_FREE: begin
							if (idx_in_range && page_used) begin
								count_q <= count_q - cnt_t'(1);
								if (hint_t'(idx_q) < hint_q) begin
									hint_q <= hint_t'(idx_q);
								end
							end
							state_q <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_SCAN: begin
					if (zero_hit[BIT_W]) begin
						hint_q  <= found_hint;
						state_q <= ST_DONE;
					end else if (word_q == LAST_WORD) begin
						hint_q  <= hint_t'(NUM_PAGES);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q       <= s_axis_tuser;
			idx_q      <= (s_axis_tuser == OP_ALLOC) ? hint_q[IDX_W-1:0] : s_axis_tdata[IDX_W-1:0];
			word_q     <= rd_addr;
			res_ok_q   <= 1'b0;
			res_free_q <= 1'b0;
			res_page_q <= s_axis_tdata[IDX_W-1:0];
		end else if (state_q == ST_RMW) begin
			if (op_q == OP_ALLOC) begin
				res_ok_q   <= 1'b1;
				res_free_q <= 1'b1;
				res_page_q <= idx_q;
				if (!zero_hit[BIT_W] && (word_q != LAST_WORD)) begin
					word_q <= scan_next;
				end
			end else if (op_q == OP_FREE) begin
				res_ok_q   <= idx_in_range && page_used;
				res_free_q <= idx_in_range && !page_used;
			end else begin
				res_ok_q   <= (op_q == OP_QUERY) && idx_in_range && !page_used;
				res_free_q <= idx_in_range && !page_used;
			end
		end else if ((state_q == ST_SCAN) && !zero_hit[BIT_W] && (word_q != LAST_WORD)) begin
			word_q <= scan_next;
		end
	end

	// Output register: loaded once the item is finished and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_ok_q    <= res_ok_q;
			m_page_q  <= res_page_q;
			m_free_q  <= res_free_q;
			m_count_q <= count_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_count_q, m_free_q, m_page_q, m_ok_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(NUM_PAGES))
		else $error("used count exceeds the number of pages");

	a_full_hint: assert property (@(posedge clk) disable iff (!arst_n)
		(hint_q == hint_t'(NUM_PAGES)) |-> (count_q == cnt_t'(NUM_PAGES)))
		else $error("hint marks the map full while pages are free");

	a_idle_hint: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) && (count_q == cnt_t'(NUM_PAGES))) |->
		(hint_q == hint_t'(NUM_PAGES)))
		else $error("full map left with a free-page hint");

	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q != ST_IDLE))
		else $error("accepted beat did not start work");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("output beat raised outside the finishing state");
`endif

endmodule
